>>> design/fde_pkg.sv
package fde_pkg;

  // Store geometry
  localparam int DEPTH   = 32768;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DELAY_W = 15;
  localparam int GAIN_W  = 16;
  localparam int SMP_W   = 16;

  // Q1.15 unity and the half-LSB rounding bias
  localparam logic [GAIN_W-1:0] ONE_Q15 = 16'd32768;
  localparam int                ROUND_Q15 = 16384;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS   = 3'd4;

  // Configuration as seen by the datapath, gains already clamped to unity
  typedef struct packed {
    logic [ADDR_W-1:0] delay;
    logic [GAIN_W-1:0] feedback;
    logic [GAIN_W-1:0] wet;
    logic [GAIN_W-1:0] dry;
    logic [GAIN_W-1:0] volume;
    logic              bypass;
  } cfg_t;

  // Clamp an 18-bit signed value to the 16-bit sample range
  function automatic logic signed [SMP_W-1:0] sat16(input logic signed [17:0] v);
    logic signed [17:0] hi;
    logic signed [17:0] lo;
    hi = 18'sd32767;
    lo = -18'sd32768;
    if (v > hi) begin
      sat16 = 16'sh7fff;
    end else if (v < lo) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[SMP_W-1:0];
    end
  endfunction

endpackage

>>> design/fde_ram.sv
module fde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> design/fde_cfg.sv
module fde_cfg
  import fde_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 we,
  input  logic [CFG_IDX_W-1:0] index,
  input  logic [GAIN_W-1:0]    data,
  output cfg_t                 cfg
);

  localparam int DCMP_W = (ADDR_W > DELAY_W) ? ADDR_W : DELAY_W;
  localparam logic [DCMP_W-1:0] DELAY_MAX = DCMP_W'(DEPTH - 1);

  logic [ADDR_W-1:0] delay;
  logic [GAIN_W-1:0] feedback;
  logic [GAIN_W-1:0] wet;
  logic [GAIN_W-1:0] volume;
  logic              bypass;

  logic [DCMP_W-1:0] delay_wide;
  logic [DCMP_W-1:0] delay_clamped;
  logic [GAIN_W-1:0] gain_clamped;
  logic [GAIN_W:0]   dry_wide;

  always_comb begin
    delay_wide    = DCMP_W'(data[DELAY_W-1:0]);
    delay_clamped = (delay_wide > DELAY_MAX) ? DELAY_MAX : delay_wide;
    gain_clamped  = (data > ONE_Q15) ? ONE_Q15 : data;
  end

  // Clamp on write, so the datapath sees only legal values
  always_ff @(posedge clk) begin
    if (rst) begin
      delay    <= '0;
      feedback <= '0;
      wet      <= 16'd16384;
      volume   <= ONE_Q15;
      bypass   <= 1'b0;
    end else if (we) begin
      case (index)
        REG_DELAY:    delay    <= delay_clamped[ADDR_W-1:0];
        REG_FEEDBACK: feedback <= gain_clamped;
        REG_WET:      wet      <= gain_clamped;
        REG_VOLUME:   volume   <= gain_clamped;
        REG_BYPASS:   bypass   <= data[0];
        default: ;
      endcase
    end
  end

  assign dry_wide = {1'b0, ONE_Q15} - {1'b0, wet};

  always_comb begin
    cfg.delay    = delay;
    cfg.feedback = feedback;
    cfg.wet      = wet;
    cfg.dry      = dry_wide[GAIN_W-1:0];
    cfg.volume   = volume;
    cfg.bypass   = bypass;
  end

endmodule

>>> design/feedback_delay_echo_top.sv
// Feedback delay echo on a stream of signed Q1.15 samples. Each sample
// transfer reads the sample written delay_samples+1 samples earlier from a
// single-port store, outputs volume * ((1-wet)*in + wet*delayed) rounded and
// saturated, and writes in + feedback*delayed (saturated) back at the write
// pointer. A processed sample goes from input transfer to output register
// through accept and read, multiply, write-back and volume multiply, and
// output load; the next input is taken in the cycle after the output
// register is loaded, so no new sample enters before the last is through,
// set by the read-then-write sequence on the store's single port and the
// two registered multiply stages. In bypass the store and pointer are left
// alone. The store needs no clearing pass after reset: a wrap flag and the
// write pointer act as a fill count, and an entry not yet written since
// reset reads as zero. Configuration is written through a plain write port
// (cfg_we, cfg_index, cfg_data); gains above unity are clamped to unity and
// the delay to the store depth minus one.
module feedback_delay_echo_top
  import fde_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,   // [15:0] in_sample
  // Output stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // [15:0] out_sample
  // Configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_MIX,
    S_OUT
  } state_t;

  state_t state;

  cfg_t cfg;

  fde_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // Write pointer and wrap flag: together they tell which entries hold data
  logic [ADDR_W-1:0] wr_ptr;
  logic              wrapped;

  // Item registers
  logic signed [SMP_W-1:0] x;
  logic                    item_byp;
  logic                    rd_ok;
  logic signed [33:0]      mix_acc;
  logic signed [32:0]      fb_acc;
  logic signed [32:0]      vol_acc;

  logic accept;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Read address: wr_ptr - 1 - delay, modulo the depth
  logic [ADDR_W:0]   rd_sum;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    rd_sum = {1'b0, wr_ptr} + (ADDR_W + 1)'(DEPTH - 1) - {1'b0, cfg.delay};
    if (rd_sum >= (ADDR_W + 1)'(DEPTH)) begin
      rd_sum = rd_sum - (ADDR_W + 1)'(DEPTH);
    end
    rd_addr = rd_sum[ADDR_W-1:0];
  end

  // Store port
  logic              ram_en;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [SMP_W-1:0]  ram_wdata;
  logic [SMP_W-1:0]  ram_rdata;

  assign ram_we   = (state == S_MIX);
  assign ram_en   = ram_we || (accept && !cfg.bypass);
  assign ram_addr = ram_we ? wr_ptr : rd_addr;

  fde_ram #(
    .WIDTH (SMP_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Read stage products
  logic signed [SMP_W-1:0] del;
  logic signed [GAIN_W:0]  dry_s;
  logic signed [GAIN_W:0]  wet_s;
  logic signed [GAIN_W:0]  fb_s;
  logic signed [GAIN_W:0]  vol_s;
  logic signed [32:0]      prod_dry;
  logic signed [32:0]      prod_wet;
  logic signed [32:0]      prod_fb;

  assign del      = rd_ok ? signed'(ram_rdata) : '0;
  assign dry_s    = signed'({1'b0, cfg.dry});
  assign wet_s    = signed'({1'b0, cfg.wet});
  assign fb_s     = signed'({1'b0, cfg.feedback});
  assign vol_s    = signed'({1'b0, cfg.volume});
  assign prod_dry = dry_s * x;
  assign prod_wet = wet_s * del;
  assign prod_fb  = fb_s * del;

  // Mix stage: round the mix, form the write-back value, scale by volume
  logic signed [SMP_W-1:0] mix;
  logic signed [17:0]      fb_round;
  logic signed [17:0]      wr_sum;
  logic signed [32:0]      prod_vol;
  logic signed [17:0]      out_round;

  assign mix       = mix_acc[30:15];
  assign fb_round  = fb_acc[32:15];
  assign wr_sum    = 18'(x) + fb_round;
  assign ram_wdata = sat16(wr_sum);
  assign prod_vol  = vol_s * mix;
  assign out_round = vol_acc[32:15];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wr_ptr   <= '0;
      wrapped  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // Drop the output once it has been taken, unless S_OUT loads a new one
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            x        <= signed'(s_tdata);
            item_byp <= cfg.bypass;
            rd_ok    <= wrapped || (rd_addr < wr_ptr);
            state    <= cfg.bypass ? S_OUT : S_READ;
          end
        end
        S_READ: begin
          mix_acc <= 34'(prod_dry) + 34'(prod_wet) + 34'(ROUND_Q15);
          fb_acc  <= prod_fb + 33'(ROUND_Q15);
          state   <= S_MIX;
        end
        S_MIX: begin
          vol_acc <= prod_vol + 33'(ROUND_Q15);
          if (wr_ptr == ADDR_W'(DEPTH - 1)) begin
            wr_ptr  <= '0;
            wrapped <= 1'b1;
          end else begin
            wr_ptr <= wr_ptr + 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          // Hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= item_byp ? x : sat16(out_round);
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The pointer moves only on a store write-back
  a_ptr_moves_on_write: assert property (@(posedge clk) disable iff (rst)
    !ram_we |=> $stable(wr_ptr))
    else $error("write pointer moved without a store write");

  // A bypassed sample never writes the store
  a_bypass_no_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !item_byp)
    else $error("store written for a bypassed sample");

  // No second input transfer while a sample is in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input taken while a sample was in flight");

endmodule

>>> sim/tb_top.sv
module tb_top;
  import fde_pkg::*;

  // Run limit in clock cycles, far above the slowest legal run
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1630;

  // Register indexes past the last one the block decodes
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_BYPASS + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

  typedef enum logic [1:0] {ROW_REG, ROW_SAMPLE, ROW_CHECKED} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          value;
    logic [SMP_W-1:0]     want;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [15:0]          s_tdata;   // [15:0] in_sample
  logic                 m_tvalid;
  logic                 m_tready;
  logic [15:0]          m_tdata;   // [15:0] out_sample
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0]    cfg_data;

  // Shadow of the echo state and the registers, advanced per accepted transfer
  logic signed [SMP_W-1:0] echo_mem [DEPTH];
  logic [ADDR_W-1:0]       wr_ptr;
  logic [DELAY_W-1:0]      set_delay;
  logic [GAIN_W-1:0]       set_feedback;
  logic [GAIN_W-1:0]       set_wet;
  logic [GAIN_W-1:0]       set_volume;
  logic                    set_bypass;

  logic [SMP_W-1:0] echo_due [$];   // output samples still to arrive, oldest first
  dir_row_t         plan [$];
  int unsigned      err_count;
  int unsigned      cycle_count;
  int unsigned      idle_pct;       // chance in percent that either side starts a gap
  int unsigned      stall_left;

  feedback_delay_echo_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Echo predictor
  // ---------------------------------------------------------------------------

  // Round half up after a Q1.15 product: floor((v + half) / 2^15)
  function automatic longint q15_round(input longint v);
    return (v + ROUND_Q15) >>> 15;
  endfunction

  function automatic longint clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Gains above unity behave as unity
  function automatic longint unity_clamp(input logic [GAIN_W-1:0] g);
    return (g > ONE_Q15) ? longint'(ONE_Q15) : longint'(g);
  endfunction

  // Mirror a register write; unknown indexes leave everything alone
  function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [GAIN_W-1:0] data);
    case (idx)
      REG_DELAY:    set_delay    = data[DELAY_W-1:0];
      REG_FEEDBACK: set_feedback = data;
      REG_WET:      set_wet      = data;
      REG_VOLUME:   set_volume   = data;
      REG_BYPASS:   set_bypass   = data[0];
      default: ;
    endcase
  endfunction

  // Output sample for one input sample; updates the shadow store and pointer
  function automatic logic [SMP_W-1:0] echo_step(input logic [SMP_W-1:0] smp);
    longint            x;
    longint            del;
    longint            w;
    longint            mix;
    longint            y;
    longint            wr;
    int                d;
    logic [ADDR_W-1:0] rd;
    if (set_bypass) return smp;
    x   = $signed(smp);
    d   = (int'(set_delay) > DEPTH - 1) ? DEPTH - 1 : int'(set_delay);
    // The delayed sample was written d+1 samples ago
    rd  = wr_ptr - ADDR_W'(1) - ADDR_W'(d);
    del = echo_mem[rd];
    w   = unity_clamp(set_wet);
    mix = q15_round((longint'(ONE_Q15) - w) * x + w * del);
    y   = clamp16(q15_round(unity_clamp(set_volume) * mix));
    wr  = clamp16(x + q15_round(unity_clamp(set_feedback) * del));
    echo_mem[wr_ptr] = SMP_W'(wr);
    wr_ptr = wr_ptr + 1'b1;
    return SMP_W'(y);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // A gap with chance pct in percent: mostly short ones, the odd long one
  function automatic int unsigned pick_gap(input int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return ONE_Q15;
      2:       return 16'h7fff;
      3:       return GAIN_W'($urandom_range(65535));   // above unity now and then
      default: return GAIN_W'($urandom_range(32768));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_delay();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 16'd1;
      2:       return GAIN_W'($urandom);                // top bit dropped by the block
      3:       return 16'd32767;
      4:       return GAIN_W'($urandom_range(400, 64));
      default: return GAIN_W'($urandom_range(63));
    endcase
  endfunction

  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return SMP_W'($urandom_range(255)) - 16'd128;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    plan.push_back('{kind: ROW_REG, idx: idx, value: data, want: '0});
  endfunction

  function automatic void add_smp(input logic [SMP_W-1:0] smp);
    plan.push_back('{kind: ROW_SAMPLE, idx: '0, value: smp, want: '0});
  endfunction

  function automatic void add_chk(input logic [SMP_W-1:0] smp, input logic [SMP_W-1:0] want);
    plan.push_back('{kind: ROW_CHECKED, idx: '0, value: smp, want: want});
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // Hold the input side quiet until every expected sample has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (echo_due.size() != 0) @(posedge clk);
  endtask

  // Registers change only with the pipeline empty. cfg_we stays high across
  // back-to-back writes and is dropped when sending of the next sample begins.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    shadow_write(idx, data);
    @(posedge clk);
  endtask

  // Offer one sample after a random gap and hold it until the transfer.
  // A typed expectation, where given, replaces the predicted one.
  task automatic send_sample(input logic [SMP_W-1:0] smp, input bit typed,
                             input logic [SMP_W-1:0] want);
    int unsigned      gap;
    logic [SMP_W-1:0] predicted;
    gap = pick_gap(idle_pct);
    cfg_we <= 1'b0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = echo_step(smp);
    echo_due.push_back(typed ? want : predicted);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure and the checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : sink_side
    int unsigned g;
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      g = pick_gap(idle_pct);
      if (g != 0) begin
        m_tready   <= 1'b0;
        stall_left <= g - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare every output transfer with the oldest expectation
  always @(posedge clk) begin : out_check
    logic [SMP_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (echo_due.size() == 0) begin
        report_mismatch($sformatf("out_sample %h with nothing pending", m_tdata));
      end else begin
        want = echo_due.pop_front();
        if (m_tdata[SMP_W-1:0] !== want)
          report_mismatch($sformatf("out_sample %h, want %h", m_tdata[SMP_W-1:0], want));
      end
    end
  end

  // Give up on a hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    int unsigned sent;
    int unsigned n;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    err_count   = 0;
    cycle_count = 0;
    stall_left  = 0;
    idle_pct    = 30;
    foreach (echo_mem[i]) echo_mem[i] = '0;
    wr_ptr       = '0;
    set_delay    = '0;
    set_feedback = '0;
    set_wet      = 16'd16384;
    set_volume   = ONE_Q15;
    set_bypass   = 1'b0;

    // Directed rows. After reset: delay 0, no feedback, half wet, unity volume.
    // The first sample meets an empty store, the second hears the first.
    add_chk(16'h7fff, 16'h4000);
    add_chk(16'h8000, 16'h0000);
    // Fully wet (gain above unity clamps) with unity feedback: output is the echo
    add_reg(REG_WET, 16'hffff);
    add_reg(REG_FEEDBACK, 16'h8000);
    add_chk(16'h7fff, 16'h8000);
    add_chk(16'h7fff, 16'hffff);
    // Store write-back saturates high, then low
    add_smp(16'h7fff);
    add_smp(16'h7fff);
    add_smp(16'h8000);
    add_smp(16'h8000);
    // Zero volume silences the output while the store keeps filling
    add_reg(REG_VOLUME, 16'h0000);
    add_chk(16'h1234, 16'h0000);
    add_chk(16'h8000, 16'h0000);
    // Dry only at unity volume passes the input through
    add_reg(REG_VOLUME, 16'h8000);
    add_reg(REG_WET, 16'h0000);
    add_chk(16'h1234, 16'h1234);
    add_chk(16'h8000, 16'h8000);
    add_chk(16'h7fff, 16'h7fff);
    // Bypass returns the input untouched; only bit 0 of the write counts
    add_reg(REG_BYPASS, 16'h0001);
    add_chk(16'h5a5a, 16'h5a5a);
    add_chk(16'hffff, 16'hffff);
    add_reg(REG_BYPASS, 16'hfffe);
    // Writes to undecoded indexes must change nothing
    add_reg(REG_SPARE_FIRST, 16'hffff);
    add_reg(REG_SPARE_LAST, 16'h0000);
    add_chk(16'h0001, 16'h0001);
    // Longest delay, bit 15 of the write dropped: reads a slot never written
    add_reg(REG_DELAY, 16'hffff);
    add_reg(REG_WET, 16'h4000);
    add_reg(REG_FEEDBACK, 16'h7fff);
    add_smp(16'h7fff);
    // Short delay with odd gains
    add_reg(REG_DELAY, 16'h0003);
    add_reg(REG_VOLUME, 16'h7fff);
    add_reg(REG_WET, 16'h0001);
    add_smp(16'h0001);
    add_smp(16'hfffe);
    add_smp(16'h4000);
    add_smp(16'hc000);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_REG:     write_reg(plan[i].idx, plan[i].value);
        ROW_SAMPLE:  send_sample(plan[i].value, 1'b0, '0);
        ROW_CHECKED: send_sample(plan[i].value, 1'b1, plan[i].want);
        default: ;
      endcase
    end

    // Random phases: fresh settings each time, the store carries over
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(2))
        0:       idle_pct = 0;
        1:       idle_pct = 30;
        default: idle_pct = 70;
      endcase
      write_reg(REG_DELAY, pick_delay());
      write_reg(REG_FEEDBACK, pick_gain());
      write_reg(REG_WET, pick_gain());
      write_reg(REG_VOLUME, pick_gain());
      write_reg(REG_BYPASS, {15'($urandom), ($urandom_range(7) == 0)});
      if ($urandom_range(3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                  GAIN_W'($urandom));
      n = $urandom_range(160, 40);
      repeat (n) begin
        send_sample(pick_sample(), 1'b0, '0);
        // Now and then let the pipeline run dry mid-phase
        if ($urandom_range(63) == 0) wait_drained();
      end
      sent += n;
    end

    // Drain, then watch a while for stray outputs
    wait_drained();
    cfg_we <= 1'b0;
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
